// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the detector RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, off during reset.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- rtl/wfg_pkg.sv -----
// Package for the wait-for graph cycle detector: modes and defaults.
// No dependencies.
package wfg_pkg;
  localparam int THREADS_DEF = 16;
  localparam int MUTEXES_DEF = 16;
  localparam int ID_W = 4;
  localparam int MODE_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD_WAIT = 3'd0,
    MODE_ADD_HOLD = 3'd1,
    MODE_REM_HOLD = 3'd2,
    MODE_REM_WAIT = 3'd3,
    MODE_DETECT   = 3'd4,
    MODE_CLEAR    = 3'd5
  } mode_t;
endpackage

// ----- rtl/wfg_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module wfg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/wait_for_graph_cycle_detector.sv -----
// An edge update steps through read, modify/write and present; clear sweeps one
// row of each matrix per cycle. Detect: one memory read per walk step; one item
// at a time. Reset clears both matrices with a row sweep while s_tready is low.
// Depends on wfg_pkg, wfg_ram and assert_macros.svh.
`include "assert_macros.svh"
module wait_for_graph_cycle_detector #(
  parameter int THREADS = wfg_pkg::THREADS_DEF,
  parameter int MUTEXES = wfg_pkg::MUTEXES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // mode[2:0], thread_id[6:3], mutex[10:7], zeros
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata   // cycle_found[0], answered_mode[3:1], zeros
);
  localparam int NODES = THREADS + MUTEXES;
  localparam int NW = $clog2(NODES);
  localparam int TW = $clog2(THREADS);
  localparam int MW = $clog2(MUTEXES);
  localparam int RMAX = (THREADS > MUTEXES) ? THREADS : MUTEXES;
  localparam int RW = $clog2(RMAX + 1);
  localparam int SW = $clog2(NODES + 1);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_UPD_RD, ST_UPD_WR, ST_ROOT, ST_NODE_RD, ST_NODE_EV,
    ST_OUT
  } state_t;

  state_t state;
  logic [wfg_pkg::MODE_W-1:0] mode;
  logic [wfg_pkg::ID_W-1:0] tid, mid;
  logic [RW-1:0] clr_idx;
  logic clr_reply;
  logic [NW:0] root;
  logic [NODES-1:0] visited, on_path;
  logic [NW-1:0] stack [NODES];
  logic [SW-1:0] depth;
  logic found;

  // Memory ports
  logic w_we, h_we;
  logic [TW-1:0] w_waddr, w_raddr;
  logic [MW-1:0] h_waddr, h_raddr;
  logic [MUTEXES-1:0] w_wdata, w_rdata;
  logic [THREADS-1:0] h_wdata, h_rdata;

  wfg_ram #(.WIDTH(MUTEXES), .DEPTH(THREADS)) u_wait (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr),
    .rdata(w_rdata));
  wfg_ram #(.WIDTH(THREADS), .DEPTH(MUTEXES)) u_hold (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr),
    .rdata(h_rdata));

  logic ids_ok;
  assign ids_ok = (32'(tid) < 32'(THREADS)) && (32'(mid) < 32'(MUTEXES));

  // Top of walk stack and its node
  logic [NW-1:0] top;
  logic top_thr;
  assign top = stack[depth[NW-1:0] - NW'(1)];
  assign top_thr = top < NW'(THREADS);

  // Read address selection
  always_comb begin
    w_raddr = TW'(tid);
    h_raddr = MW'(mid);
    if (state == ST_NODE_RD) begin
      w_raddr = top[TW-1:0];
      h_raddr = MW'(top - NW'(THREADS));
    end
  end

  // Neighbor masks of the top node over all nodes
  logic [NODES-1:0] nbr, hit_on, hit_new;
  always_comb begin
    nbr = '0;
    if (top_thr) nbr[NODES-1:THREADS] = w_rdata;
    else         nbr[THREADS-1:0] = h_rdata;
    hit_on = nbr & on_path;
    hit_new = nbr & ~visited;
  end

  // Lowest unvisited neighbor
  logic [NW-1:0] nxt;
  always_comb begin
    nxt = '0;
    for (int i = NODES - 1; i >= 0; i--) if (hit_new[i]) nxt = NW'(i);
  end

  // Write port control
  always_comb begin
    w_we = 1'b0; h_we = 1'b0;
    w_waddr = TW'(tid); h_waddr = MW'(mid);
    w_wdata = w_rdata; h_wdata = h_rdata;
    if (state == ST_CLR) begin
      w_we = clr_idx < RW'(THREADS);
      h_we = clr_idx < RW'(MUTEXES);
      w_waddr = TW'(clr_idx); h_waddr = MW'(clr_idx);
      w_wdata = '0; h_wdata = '0;
    end else if (state == ST_UPD_WR && ids_ok) begin
      unique case (mode)
        wfg_pkg::MODE_ADD_WAIT: begin
          w_we = 1'b1; w_wdata = w_rdata | (MUTEXES'(1) << MW'(mid));
        end
        wfg_pkg::MODE_REM_WAIT: begin
          w_we = 1'b1; w_wdata = w_rdata & ~(MUTEXES'(1) << MW'(mid));
        end
        wfg_pkg::MODE_ADD_HOLD: begin
          h_we = 1'b1; h_wdata = h_rdata | (THREADS'(1) << TW'(tid));
        end
        wfg_pkg::MODE_REM_HOLD: begin
          h_we = 1'b1; h_wdata = h_rdata & ~(THREADS'(1) << TW'(tid));
        end
        default: ;
      endcase
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata = {4'b0, mode, found};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      clr_idx <= '0;
      clr_reply <= 1'b0;
      found <= 1'b0;
      depth <= '0;
    end else begin
      unique case (state)
        ST_CLR: begin
          clr_idx <= clr_idx + RW'(1);
          if (clr_idx == RW'(RMAX - 1)) begin
            state <= clr_reply ? ST_OUT : ST_IDLE;
            clr_reply <= 1'b0;
          end
        end
        ST_IDLE: if (s_tvalid) begin
          mode <= s_tdata[2:0];
          tid <= s_tdata[6:3];
          mid <= s_tdata[10:7];
          found <= 1'b0;
          if (s_tdata[2:0] == wfg_pkg::MODE_DETECT) begin
            state <= ST_ROOT;
            root <= '0; visited <= '0; on_path <= '0; depth <= '0;
          end else if (s_tdata[2:0] == wfg_pkg::MODE_CLEAR) begin
            state <= ST_CLR; clr_idx <= '0;
            clr_reply <= 1'b1;
          end else state <= ST_UPD_RD;
        end
        ST_UPD_RD: state <= ST_UPD_WR;
        ST_UPD_WR: state <= ST_OUT;
        ST_ROOT: begin
          if (root == (NW+1)'(NODES)) state <= ST_OUT;
          else if (visited[root[NW-1:0]]) root <= root + (NW+1)'(1);
          else begin
            visited[root[NW-1:0]] <= 1'b1;
            on_path[root[NW-1:0]] <= 1'b1;
            stack[0] <= root[NW-1:0];
            depth <= SW'(1);
            state <= ST_NODE_RD;
          end
        end
        ST_NODE_RD: state <= ST_NODE_EV;
        ST_NODE_EV: begin
          if (|hit_on) begin
            found <= 1'b1; state <= ST_OUT;
          end else if (|hit_new) begin
            visited[nxt] <= 1'b1; on_path[nxt] <= 1'b1;
            stack[depth[NW-1:0]] <= nxt;
            depth <= depth + SW'(1);
            state <= ST_NODE_RD;
          end else begin
            on_path[top] <= 1'b0;
            depth <= depth - SW'(1);
            if (depth == SW'(1)) begin
              state <= ST_ROOT; root <= root + (NW+1)'(1);
            end else state <= ST_NODE_RD;
          end
        end
        ST_OUT: if (m_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `ASSERT_IMPL(a_found_only_detect, clk, rst, m_tvalid && m_tdata[0],
    m_tdata[3:1] == wfg_pkg::MODE_DETECT)
  `ASSERT_NEXT(a_out_holds, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `ASSERT_IMPL(a_no_accept_busy, clk, rst, s_tready, !m_tvalid)
endmodule
